// ===== sv/s2ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// s2ptw_pkg
// Types, codes and helper functions shared by the stage-2 table walker.
// ----------------------------------------------------------------------------
package s2ptw_pkg;

	// Physical address bits implemented by the walker
	localparam int PA_BITS = 48;
	localparam logic [47:0] PA_MASK = 48'((64'd1 << PA_BITS) - 64'd1);

	// Input size limits (64 - T0SZ)
	localparam logic [6:0] IA_MIN_BITS = 7'd25;
	localparam logic [6:0] IA_MAX_BITS = 7'd48;

	// Configuration register indexes
	localparam logic [2:0] CFG_T0SZ       = 3'd0;
	localparam logic [2:0] CFG_GRANULE    = 3'd1;
	localparam logic [2:0] CFG_SL0        = 3'd2;
	localparam logic [2:0] CFG_OA_BITS    = 3'd3;
	localparam logic [2:0] CFG_TABLE_BASE = 3'd4;
	localparam logic [2:0] CFG_BIG_ENDIAN = 3'd5;

	// Granule codes
	localparam logic [1:0] GRAN_4K  = 2'd0;
	localparam logic [1:0] GRAN_16K = 2'd1;

	// Request kinds
	localparam logic KIND_TRANSLATE = 1'b0;
	localparam logic KIND_DESC      = 1'b1;

	// Result kinds
	localparam logic [1:0] RK_READ   = 2'd0;
	localparam logic [1:0] RK_DONE   = 2'd1;
	localparam logic [1:0] RK_FAULT  = 2'd2;
	localparam logic [1:0] RK_BADCFG = 2'd3;

	// Fault status codes, level goes in the low two bits
	localparam logic [5:0] FSC_ADDRSZ = 6'h00;
	localparam logic [5:0] FSC_TRANS  = 6'h04;
	localparam logic [5:0] FSC_ACCESS = 6'h08;

	// Descriptor encoding
	localparam logic [1:0] DESC_TABLE = 2'b11;
	localparam logic [1:0] DESC_BLOCK = 2'b01;
	localparam int DESC_AF_BIT = 10;
	localparam int DESC_RD_BIT = 6;
	localparam int DESC_WR_BIT = 7;
	localparam logic [1:0] LAST_LEVEL = 2'd3;

	typedef struct packed {
		logic [5:0]  t0sz;
		logic [1:0]  granule;
		logic [1:0]  sl0;
		logic [5:0]  oa_bits;
		logic [47:0] table_base;
		logic        big_endian;
	} cfg_t;

	typedef struct packed {
		logic        busy;
		logic [47:0] ipa;
		logic [1:0]  level;
		logic [5:0]  top_bit;
		logic [47:0] base;
	} walk_t;

	typedef struct packed {
		logic        kind;
		logic [47:0] ipa;
		logic [63:0] descriptor;
	} item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [47:0] addr;
		logic [5:0]  fault_code;
		logic [1:0]  level;
		logic [5:0]  block_size_log2;
		logic        readable;
		logic        writable;
		logic [63:0] last_descriptor;
	} result_t;

	// Bits hi down to lo set, clipped to 48 bits; empty when lo > hi
	function automatic logic [47:0] span48(input logic [6:0] hi, input logic [6:0] lo);
		logic [47:0] m;
		for (int i = 0; i < 48; i++) begin
			m[i] = (7'(i) <= hi) && (7'(i) >= lo);
		end
		return m;
	endfunction

	function automatic logic [4:0] page_shift(input logic [1:0] gran);
		logic [4:0] ps;
		unique case (gran)
			GRAN_4K:  ps = 5'd12;
			GRAN_16K: ps = 5'd14;
			default:  ps = 5'd16;
		endcase
		return ps;
	endfunction

	// Lowest IPA bit resolved by a lookup at the given level
	function automatic logic [5:0] bottom_bit(input logic [1:0] gran, input logic [1:0] lvl);
		logic [4:0] ps;
		logic [1:0] steps;
		ps = page_shift(gran);
		steps = 2'd3 - lvl;
		return 6'({4'd0, steps} * {1'b0, ps - 5'd3} + {1'b0, ps});
	endfunction

	// Output address size check against the configured limit
	function automatic logic oa_bad(input logic [47:0] v, input logic [5:0] oab);
		return (oab < 6'(PA_BITS)) && (|(v & span48(7'(PA_BITS - 1), {1'b0, oab})));
	endfunction

endpackage

// ===== sv/s2ptw_if.sv =====
// ----------------------------------------------------------------------------
// s2ptw channel interfaces
// Valid/ready channels for walker requests, results and register writes.
// ----------------------------------------------------------------------------
interface s2ptw_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [47:0] ipa;
	logic [63:0] descriptor;

	modport source (output valid, kind, ipa, descriptor, input ready);
	modport sink (input valid, kind, ipa, descriptor, output ready);
endinterface

interface s2ptw_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [47:0] addr;
	logic [5:0]  fault_code;
	logic [1:0]  level;
	logic [5:0]  block_size_log2;
	logic        readable;
	logic        writable;
	logic [63:0] last_descriptor;

	modport source (output valid, result_kind, addr, fault_code, level, block_size_log2,
		readable, writable, last_descriptor, input ready);
	modport sink (input valid, result_kind, addr, fault_code, level, block_size_log2,
		readable, writable, last_descriptor, output ready);
endinterface

interface s2ptw_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/stage2_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// stage2_page_table_walker
// Stage-2 translation table walker, one walk in flight, one request per cycle unless a held result stalls.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                      | accepted when
//  --------+-----+----------------------------------------------+--------------------
//  req     | in  | kind, ipa, descriptor                        | req.valid & ready
//  rsp     | out | kind, addr, fsc, level, size, r/w, last desc | rsp.valid & ready
//  cfg     | in  | index, data (register write)                 | cfg.valid & ready
//
//  Flow: a request is captured in the input register and evaluated by the
//  step logic in the following cycle; its result lands in the result register,
//  which drives rsp.valid. One request per cycle unless a held result stalls.
//  Reset: arst_n clears the channel valids and the walk state and loads the
//  register defaults (T0SZ 24, 4K granule, SL0 0, 48 output bits, base 0, LE).
//  Stalls: a held result blocks the input register only; a stray descriptor
//  with no walk running is dropped without needing result space.
//  cfg.ready is always high.
//
module stage2_page_table_walker (
	input  logic        clk,
	input  logic        arst_n,
	s2ptw_req_if.sink   req,
	s2ptw_rsp_if.source rsp,
	s2ptw_cfg_if.sink   cfg
);
	import s2ptw_pkg::*;

	cfg_t    cfg_regs;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	walk_t   walk_q;

	walk_t   walk_nxt;
	result_t step_res;
	logic    step_has_result;
	logic    req_acc;
	logic    advance;

	// Register file, writes land immediately
	assign cfg.ready = 1'b1;

	s2ptw_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// Input register: hold the request until the step logic can retire it
	assign req_acc = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_s1.kind       <= req.kind;
			item_s1.ipa        <= req.ipa;
			item_s1.descriptor <= req.descriptor;
		end
	end

	// Step logic sees the walk state left by the previous request
	s2ptw_step u_step (
		.cfg        (cfg_regs),
		.cur        (walk_q),
		.item       (item_s1),
		.nxt        (walk_nxt),
		.res        (step_res),
		.has_result (step_has_result)
	);

	// Advance when the result slot is free or drains this cycle; drop needs no slot
	assign advance   = valid_s1 && (!step_has_result || !valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			walk_q   <= '0;
		end else begin
			valid_s1 <= req_acc || (valid_s1 && !advance);
			if (advance && step_has_result) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				walk_q <= walk_nxt;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance && step_has_result) begin
			result_s2 <= step_res;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.result_kind     = result_s2.result_kind;
	assign rsp.addr            = result_s2.addr;
	assign rsp.fault_code      = result_s2.fault_code;
	assign rsp.level           = result_s2.level;
	assign rsp.block_size_log2 = result_s2.block_size_log2;
	assign rsp.readable        = result_s2.readable;
	assign rsp.writable        = result_s2.writable;
	assign rsp.last_descriptor = result_s2.last_descriptor;

`ifndef ASSERT_OFF
	// A read keeps the walk alive at the level it reports
	a_read_keeps_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_has_result && step_res.result_kind == RK_READ)
		|=> (walk_q.busy && walk_q.level == $past(step_res.level)))
		else $error("read issued but walk state not advanced");

	// Any terminal result ends the walk
	a_terminal_ends_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_has_result && step_res.result_kind != RK_READ)
		|=> !walk_q.busy)
		else $error("walk still busy after terminal result");

	// Only a stray descriptor goes without a result
	a_drop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step_has_result)
		|-> (item_s1.kind == KIND_DESC && !walk_q.busy))
		else $error("request dropped while a walk is running");

	// A finished translation maps at least one page
	a_done_block_size: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.result_kind == RK_DONE)
		|-> (result_s2.block_size_log2 >= 6'd12 && result_s2.fault_code == FSC_ADDRSZ))
		else $error("bad block size on completed translation");
`endif

endmodule

// ===== sv/s2ptw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// s2ptw_cfg_regs
// Walker configuration registers, written one index at a time.
// ----------------------------------------------------------------------------
module s2ptw_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [47:0]       wr_data,
	output s2ptw_pkg::cfg_t   cfg
);
	import s2ptw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.t0sz       <= 6'd24;
			cfg_q.granule    <= GRAN_4K;
			cfg_q.sl0        <= 2'd0;
			cfg_q.oa_bits    <= 6'd48;
			cfg_q.table_base <= '0;
			cfg_q.big_endian <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_T0SZ:       cfg_q.t0sz       <= wr_data[5:0];
				CFG_GRANULE:    cfg_q.granule    <= wr_data[1:0];
				CFG_SL0:        cfg_q.sl0        <= wr_data[1:0];
				CFG_OA_BITS:    cfg_q.oa_bits    <= wr_data[5:0];
				CFG_TABLE_BASE: cfg_q.table_base <= wr_data;
				CFG_BIG_ENDIAN: cfg_q.big_endian <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/s2ptw_step.sv =====
// ----------------------------------------------------------------------------
// s2ptw_step
// One walk step: start a walk or consume a descriptor, give result and state.
// ----------------------------------------------------------------------------
module s2ptw_step (
	input  s2ptw_pkg::cfg_t    cfg,
	input  s2ptw_pkg::walk_t   cur,
	input  s2ptw_pkg::item_t   item,
	output s2ptw_pkg::walk_t   nxt,
	output s2ptw_pkg::result_t res,
	output logic               has_result
);
	import s2ptw_pkg::*;

	// Walk start
	logic [4:0]        ps;
	logic [6:0]        isz;
	logic [1:0]        lvl_st;
	logic              lvl_neg;
	logic [5:0]        bot_st;
	logic signed [7:0] root_bits;
	logic [4:0]        base_lo;
	logic              cfg_bad;
	logic [47:0]       base_st;

	// Descriptor
	logic [63:0] d;
	logic [5:0]  bot_c;
	logic [1:0]  first_block;
	logic        d_oa_bad;

	// Next read
	logic        is_start;
	logic [47:0] rd_ipa;
	logic [1:0]  rd_lvl;
	logic [5:0]  rd_top;
	logic [47:0] rd_base;
	logic [5:0]  rd_bot;
	logic [47:0] rd_idx;
	logic [47:0] rd_addr;

	assign ps      = page_shift(cfg.granule);
	assign isz     = 7'(7'd64 - {1'b0, cfg.t0sz});
	assign lvl_st  = 2'(((cfg.granule == GRAN_4K) ? 2'd2 : 2'd3) - cfg.sl0);
	assign lvl_neg = (cfg.granule == GRAN_4K) && (cfg.sl0 == 2'd3);
	assign bot_st  = bottom_bit(cfg.granule, lvl_st);
	assign root_bits = $signed({1'b0, isz}) - $signed({2'b00, bot_st});
	assign base_lo = 5'(root_bits[4:0] + 5'd3);
	assign base_st = cfg.table_base & span48(7'(PA_BITS - 1), {2'b00, base_lo});

	always_comb begin
		cfg_bad = (isz > IA_MAX_BITS) || (isz < IA_MIN_BITS);
		priority if (cfg.granule == GRAN_4K) begin
			if (lvl_neg || (lvl_st == 2'd0 && isz <= 7'd42)) cfg_bad = 1'b1;
		end else if (cfg.granule == GRAN_16K) begin
			if (lvl_st == 2'd0 || (lvl_st == 2'd1 && isz <= 7'd40)) cfg_bad = 1'b1;
		end else begin
			if (lvl_st == 2'd0 || (lvl_st == 2'd1 && isz <= 7'd42)) cfg_bad = 1'b1;
		end
		if (root_bits < 8'sd1 || root_bits > $signed({3'b000, ps + 5'd1}))
			cfg_bad = 1'b1;
	end

	// Byte-swap big-endian descriptors
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			d[8*(7-i) +: 8] = cfg.big_endian ? item.descriptor[8*i +: 8]
				: item.descriptor[8*(7-i) +: 8];
		end
	end

	assign bot_c       = bottom_bit(cfg.granule, cur.level);
	assign first_block = (cfg.granule == GRAN_4K) ? 2'd1 : 2'd2;
	assign d_oa_bad    = oa_bad(d[47:0], cfg.oa_bits);

	// Next descriptor read, either first lookup or following a table
	assign is_start = (item.kind == KIND_TRANSLATE);
	assign rd_ipa   = is_start ? item.ipa : cur.ipa;
	assign rd_lvl   = is_start ? lvl_st : 2'(cur.level + 2'd1);
	assign rd_top   = is_start ? 6'(isz - 7'd1) : 6'(bot_c - 6'd1);
	assign rd_base  = is_start ? base_st
		: (d[47:0] & span48(7'(PA_BITS - 1), {2'b00, ps}));
	assign rd_bot   = bottom_bit(cfg.granule, rd_lvl);
	assign rd_idx   = (rd_ipa & span48({1'b0, rd_top}, {1'b0, rd_bot})) >> (rd_bot - 6'd3);
	assign rd_addr  = (rd_base | rd_idx) & PA_MASK;

	always_comb begin
		nxt        = cur;
		res        = '0;
		has_result = 1'b1;
		if (is_start) begin
			nxt.busy = 1'b0;
			if (cfg_bad) begin
				res.result_kind = RK_BADCFG;
				res.level       = lvl_st;
			end else if (oa_bad(base_st, cfg.oa_bits)) begin
				res.result_kind = RK_FAULT;
				res.fault_code  = FSC_ADDRSZ | {4'd0, lvl_st};
				res.level       = lvl_st;
			end else begin
				nxt.busy    = 1'b1;
				nxt.ipa     = rd_ipa;
				nxt.level   = rd_lvl;
				nxt.top_bit = rd_top;
				nxt.base    = rd_base;
				res.result_kind = RK_READ;
				res.addr        = rd_addr;
				res.level       = rd_lvl;
			end
		end else if (!cur.busy) begin
			// Stray descriptor with no walk running
			has_result = 1'b0;
		end else begin
			res.level           = cur.level;
			res.last_descriptor = d;
			nxt.busy            = 1'b0;
			if (!d[0] || (d[1:0] == DESC_BLOCK && cur.level == LAST_LEVEL)) begin
				res.result_kind = RK_FAULT;
				res.fault_code  = FSC_TRANS | {4'd0, cur.level};
			end else if (d[1:0] == DESC_TABLE && cur.level != LAST_LEVEL) begin
				if (d_oa_bad) begin
					res.result_kind = RK_FAULT;
					res.fault_code  = FSC_ADDRSZ | {4'd0, cur.level};
				end else begin
					nxt.busy    = 1'b1;
					nxt.level   = rd_lvl;
					nxt.top_bit = rd_top;
					nxt.base    = rd_base;
					res.result_kind = RK_READ;
					res.addr        = rd_addr;
					res.level       = rd_lvl;
				end
			end else if (cur.level < first_block) begin
				res.result_kind = RK_FAULT;
				res.fault_code  = FSC_TRANS | {4'd0, cur.level};
			end else if (d_oa_bad) begin
				res.result_kind = RK_FAULT;
				res.fault_code  = FSC_ADDRSZ | {4'd0, cur.level};
			end else if (!d[DESC_AF_BIT]) begin
				res.result_kind = RK_FAULT;
				res.fault_code  = FSC_ACCESS | {4'd0, cur.level};
			end else begin
				res.result_kind     = RK_DONE;
				res.addr            = (d[47:0] & span48(7'(PA_BITS - 1), {1'b0, bot_c}))
					| (cur.ipa & span48(7'(bot_c - 6'd1), 7'd0));
				res.block_size_log2 = bot_c;
				res.readable        = d[DESC_RD_BIT];
				res.writable        = d[DESC_WR_BIT];
			end
		end
	end

endmodule
